FILE: hdl/cire_pkg.sv
// shared types, constants and helpers for the canopy interception block
// no dependencies
package cire_pkg;

    localparam int LAYERS  = 2;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [15:0] FULL_COVER = 16'd32768;
    localparam logic [15:0] HEIGHT_MIN = 16'd36;
    localparam logic [10:0] LEAF_GAIN  = 11'd1580;
    localparam logic [26:0] LEAF_OFS   = 27'd2404352;
    // 1600000 = 2^9 * 3125 and 8388608000 = 2^26 * 125
    localparam logic [11:0] LEAF_ODD     = 12'd3125;
    localparam logic [28:0] LEAF_RECIP   = 29'd351843721;  // ceil(2^40 / 3125)
    localparam logic [11:0] DIRECT_ODD   = 12'd125;
    localparam logic [28:0] DIRECT_RECIP = 29'd8589935;    // ceil(2^30 / 125)
    localparam logic [17:0] LOG_K      = 18'd166507;
    localparam logic [24:0] LOG_C      = 25'h1EFA148; // -1072824
    localparam logic [16:0] DT_RESET   = 17'd3600;

    localparam logic [2:0] REG_CAP_U  = 3'd0;
    localparam logic [2:0] REG_CAP_L  = 3'd1;
    localparam logic [2:0] REG_FRAC_U = 3'd2;
    localparam logic [2:0] REG_FRAC_L = 3'd3;
    localparam logic [2:0] REG_HGT_U  = 3'd4;
    localparam logic [2:0] REG_HGT_L  = 3'd5;
    localparam logic [2:0] REG_UNDER  = 3'd6;
    localparam logic [2:0] REG_DT     = 3'd7;

    typedef struct packed {
        logic [23:0] cap_u;
        logic [23:0] cap_l;
        logic [15:0] frac_u;
        logic [15:0] frac_l;
        logic [15:0] hgt_u;
        logic [15:0] hgt_l;
        logic        under;
        logic [16:0] dt;
    } t_cfg;

    typedef struct packed {
        logic [23:0] p0;
        logic [25:0] p;
        logic [23:0] st_u;
        logic [23:0] st_l;
    } t_job;

    function automatic logic [15:0] clamp_frac(input logic [15:0] f);
        clamp_frac = (f > FULL_COVER) ? FULL_COVER : f;
    endfunction

endpackage

FILE: hdl/cire_front.sv
// front end: takes a transaction and runs the layer interception, one layer at a time
// depends on cire_pkg
module cire_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cire_pkg::t_cfg  i_cfg,
    input  logic            i_push,
    input  logic [23:0]     i_precip_depth,
    input  logic [1:0]      i_active_layers,
    output logic            o_busy,
    input  logic            i_q_full,
    output logic            o_job_push,
    output cire_pkg::t_job  o_job
);
    import cire_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_UPD  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate             r_state;
    logic [23:0]         r_p0;
    logic [25:0]         r_p;
    logic [25:0]         r_pf;
    logic                r_layer;
    logic [1:0]          r_nact;
    logic [23:0]         r_store_u;
    logic [23:0]         r_store_l;

    logic [15:0]         cur_frac;
    logic [23:0]         cur_cap;
    logic [23:0]         cur_store;
    logic [41:0]         mul;
    logic signed [26:0]  avail;
    logic signed [26:0]  pf_s;
    logic signed [26:0]  take;
    logic [25:0]         n_p;
    logic [23:0]         n_store;
    logic                layer_go;

    always_comb begin
        cur_frac  = r_layer ? clamp_frac(i_cfg.frac_l) : clamp_frac(i_cfg.frac_u);
        cur_cap   = r_layer ? i_cfg.cap_l : i_cfg.cap_u;
        cur_store = r_layer ? r_store_l : r_store_u;
        mul       = r_p * cur_frac;
        avail     = $signed({3'b000, cur_cap}) - $signed({3'b000, cur_store});
        pf_s      = $signed({1'b0, r_pf});
        take      = (avail > pf_s) ? pf_s : avail;
        n_p       = r_p - take[25:0];
        n_store   = cur_store + take[23:0];
        layer_go  = ({1'b0, r_layer} < r_nact);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_store_u <= '0;
            r_store_l <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_p0    <= i_precip_depth;
                        r_p     <= {2'b00, i_precip_depth};
                        r_nact  <= (i_active_layers > 2'd2) ? 2'd2 : i_active_layers;
                        r_layer <= 1'b0;
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    if (layer_go) begin
                        r_pf    <= mul[40:15];
                        r_state <= F_UPD;
                    end else begin
                        r_state <= F_PUSH;
                    end
                end
                F_UPD: begin
                    r_p <= n_p;
                    if (r_layer) begin
                        r_store_l <= n_store;
                        r_state   <= F_PUSH;
                    end else begin
                        r_store_u <= n_store;
                        r_layer   <= 1'b1;
                        r_state   <= F_MUL;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != F_IDLE);
    assign o_job_push  = (r_state == F_PUSH) && !i_q_full;
    assign o_job.p0    = r_p0;
    assign o_job.p     = r_p;
    assign o_job.st_u  = r_store_u;
    assign o_job.st_l  = r_store_l;

endmodule

FILE: hdl/cire_fifo.sv
// short queue of interception results between front and back end
// depends on cire_pkg
module cire_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cire_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output cire_pkg::t_job  o_data
);
    import cire_pkg::*;

    t_job                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

FILE: hdl/cire_back.sv
// back end: kinetic energy from sqrt, log2, multiply and a shared reciprocal divider
// depends on cire_pkg; holds the result register
module cire_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cire_pkg::t_cfg  i_cfg,
    input  logic            i_q_empty,
    input  cire_pkg::t_job  i_job,
    output logic            o_q_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [23:0]     o_throughfall_depth,
    output logic [31:0]     o_kinetic_energy,
    output logic [23:0]     o_storage_upper_now,
    output logic [23:0]     o_storage_lower_now
);
    import cire_pkg::*;

    typedef enum logic [13:0] {
        B_IDLE = 14'b00000000000001,
        B_SQRT = 14'b00000000000010,
        B_TMUL = 14'b00000000000100,
        B_LMUL = 14'b00000000001000,
        B_DQ   = 14'b00000000010000,
        B_DR   = 14'b00000000100000,
        B_NORM = 14'b00000001000000,
        B_LOG  = 14'b00000010000000,
        B_DMUL = 14'b00000100000000,
        B_D16  = 14'b00001000000000,
        B_AMUL = 14'b00010000000000,
        B_BMUL = 14'b00100000000000,
        B_BSUM = 14'b01000000000000,
        B_FIN  = 14'b10000000000000
    } t_bstate;

    t_bstate             r_state;
    t_job                r_job;
    logic [31:0]         r_rad;
    logic [16:0]         r_srem;
    logic [15:0]         r_root;
    logic [5:0]          r_cnt;
    logic [26:0]         r_t;
    logic [47:0]         r_num;
    logic [11:0]         r_rem;
    logic [47:0]         r_quo;
    logic [27:0]         r_dy;
    logic [15:0]         r_qd;
    logic                r_div_sel;
    logic                r_log_sel;
    logic [33:0]         r_leaf;
    logic [33:0]         r_e1;
    logic [31:0]         r_y;
    logic [4:0]          r_n;
    logic [15:0]         r_frac;
    logic [20:0]         r_lp;
    logic [20:0]         r_ld;
    logic signed [40:0]  r_dprod;
    logic [22:0]         r_d16;
    logic [46:0]         r_a;
    logic [39:0]         r_lo;
    logic [38:0]         r_hi;
    logic                r_out_vld;
    logic [23:0]         r_tf_out;
    logic [31:0]         r_ke_out;
    logic [23:0]         r_su_out;
    logic [23:0]         r_sl_out;

    logic [15:0]         h_sel;
    logic [18:0]         srem_sh;
    logic [18:0]         trial;
    logic                sq_ge;
    logic                leaf_zero;
    logic [52:0]         lmul;
    logic [27:0]         div_y;
    logic [28:0]         div_m;
    logic [56:0]         div_prod;
    logic [15:0]         div_q;
    logic [11:0]         div_c;
    logic [27:0]         div_qc;
    logic [27:0]         div_r;
    logic [11:0]         rem_nx;
    logic [47:0]         quo_nx;
    logic [63:0]         sq;
    logic [32:0]         z;
    logic [15:0]         frac_nx;
    logic [16:0]         dt_eff;
    logic [15:0]         f0;
    logic                direct_zero;
    logic signed [21:0]  diff;
    logic signed [40:0]  dmul;
    logic signed [40:0]  d16_w;
    logic                d16_pos;
    logic [46:0]         amul;
    logic [15:0]         g;
    logic [62:0]         bsum;
    logic [34:0]         ke_sum;
    logic                out_free;
    logic                out_load;

    always_comb begin
        h_sel       = i_cfg.under ? i_cfg.hgt_l : i_cfg.hgt_u;
        srem_sh     = {r_srem, r_rad[31:30]};
        trial       = {1'b0, r_root, 2'b01};
        sq_ge       = (srem_sh >= trial);
        leaf_zero   = (i_cfg.under && (i_cfg.hgt_l < HEIGHT_MIN)) || (r_t <= LEAF_OFS);
        lmul        = r_job.p * (r_t - LEAF_OFS);
        // one 16-bit quotient digit per pass, remainder stays below the odd divisor
        div_y       = {r_rem, r_num[47:32]};
        div_m       = r_div_sel ? DIRECT_RECIP : LEAF_RECIP;
        div_prod    = div_y * div_m;
        div_q       = r_div_sel ? div_prod[45:30] : div_prod[55:40];
        div_c       = r_div_sel ? DIRECT_ODD : LEAF_ODD;
        div_qc      = r_qd * div_c;
        div_r       = r_dy - div_qc;
        rem_nx      = div_r[11:0];
        quo_nx      = {r_quo[31:0], r_qd};
        sq          = r_y * r_y;
        z           = sq[63:31];
        frac_nx     = {r_frac[14:0], z[32]};
        dt_eff      = (i_cfg.dt == '0) ? 17'd1 : i_cfg.dt;
        f0          = clamp_frac(i_cfg.frac_u);
        direct_zero = i_cfg.under || (r_job.p0 == '0) || (f0 == FULL_COVER);
        diff        = $signed({1'b0, r_lp}) - $signed({1'b0, r_ld});
        dmul        = $signed({1'b0, LOG_K}) * diff;
        d16_w       = (r_dprod >>> 16) + $signed({{16{LOG_C[24]}}, LOG_C});
        d16_pos     = !d16_w[40] && (d16_w != '0);
        amul        = r_job.p0 * r_d16;
        g           = FULL_COVER - f0;
        bsum        = {r_hi, 24'd0} + {23'd0, r_lo};
        ke_sum      = {1'b0, r_leaf} + {1'b0, r_e1};
        out_free    = !r_out_vld || i_pop;
        out_load    = (r_state == B_FIN) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_job;
                        r_rad   <= {h_sel, 16'd0};
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_cnt   <= 6'd15;
                        r_state <= B_SQRT;
                    end
                end
                B_SQRT: begin
                    r_rad  <= {r_rad[29:0], 2'b00};
                    r_srem <= sq_ge ? 17'(srem_sh - trial) : srem_sh[16:0];
                    r_root <= {r_root[14:0], sq_ge};
                    if (r_cnt == '0) begin
                        r_state <= B_TMUL;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                B_TMUL: begin
                    r_t     <= LEAF_GAIN * r_root;
                    r_state <= B_LMUL;
                end
                B_LMUL: begin
                    // power of two part of the divisor taken off first
                    r_num     <= leaf_zero ? '0 : {4'd0, lmul[52:9]};
                    r_rem     <= '0;
                    r_quo     <= '0;
                    r_div_sel <= 1'b0;
                    r_cnt     <= 6'd2;
                    r_state   <= B_DQ;
                end
                B_DQ: begin
                    r_dy    <= div_y;
                    r_qd    <= div_q;
                    r_num   <= {r_num[31:0], 16'd0};
                    r_state <= B_DR;
                end
                B_DR: begin
                    r_rem <= rem_nx;
                    r_quo <= quo_nx;
                    if (r_cnt != '0) begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= B_DQ;
                    end else if (r_div_sel) begin
                        r_e1    <= quo_nx[33:0];
                        r_state <= B_FIN;
                    end else begin
                        r_leaf <= quo_nx[33:0];
                        if (direct_zero) begin
                            r_e1    <= '0;
                            r_state <= B_FIN;
                        end else begin
                            r_y       <= {8'd0, r_job.p0};
                            r_n       <= 5'd31;
                            r_log_sel <= 1'b0;
                            r_state   <= B_NORM;
                        end
                    end
                end
                B_NORM: begin
                    if (r_y[31]) begin
                        r_cnt   <= 6'd15;
                        r_frac  <= '0;
                        r_state <= B_LOG;
                    end else begin
                        r_y <= {r_y[30:0], 1'b0};
                        r_n <= r_n - 1'b1;
                    end
                end
                B_LOG: begin
                    r_frac <= frac_nx;
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_y   <= z[32] ? z[32:1] : z[31:0];
                    end else if (!r_log_sel) begin
                        r_lp      <= {r_n, frac_nx};
                        r_y       <= {15'd0, dt_eff};
                        r_n       <= 5'd31;
                        r_log_sel <= 1'b1;
                        r_state   <= B_NORM;
                    end else begin
                        r_ld    <= {r_n, frac_nx};
                        r_state <= B_DMUL;
                    end
                end
                B_DMUL: begin
                    r_dprod <= dmul;
                    r_state <= B_D16;
                end
                B_D16: begin
                    if (d16_pos) begin
                        r_d16   <= d16_w[22:0];
                        r_state <= B_AMUL;
                    end else begin
                        r_e1    <= '0;
                        r_state <= B_FIN;
                    end
                end
                B_AMUL: begin
                    r_a     <= amul;
                    r_state <= B_BMUL;
                end
                B_BMUL: begin
                    r_lo    <= r_a[23:0] * g;
                    r_hi    <= r_a[46:24] * g;
                    r_state <= B_BSUM;
                end
                B_BSUM: begin
                    r_num     <= {11'd0, bsum[62:26]};
                    r_rem     <= '0;
                    r_quo     <= '0;
                    r_div_sel <= 1'b1;
                    r_cnt     <= 6'd2;
                    r_state   <= B_DQ;
                end
                B_FIN: begin
                    if (out_free) begin
                        r_tf_out  <= (r_job.p[25:24] != 2'b00) ? 24'hFFFFFF : r_job.p[23:0];
                        r_ke_out  <= (ke_sum[34:32] != 3'b000) ? 32'hFFFFFFFF : ke_sum[31:0];
                        r_su_out  <= r_job.st_u;
                        r_sl_out  <= r_job.st_l;
                        r_state   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_q_pop             = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty             = !r_out_vld;
    assign o_throughfall_depth = r_tf_out;
    assign o_kinetic_energy    = r_ke_out;
    assign o_storage_upper_now = r_su_out;
    assign o_storage_lower_now = r_sl_out;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("back end state not one-hot");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DQ) |-> (r_rem < div_c))
        else $error("divider remainder not below divisor");

endmodule

FILE: hdl/canopy_interception_and_rain_energy.sv
// Canopy interception and rainfall kinetic energy. One transaction in, one out.
// After accepting a transaction the front end holds full high while it runs the
// zero, one or two active layers, longer if the two-entry queue has no room.
// The back end sets the rate and takes a new transaction only after the last one.
// With an understory, zero rain or full upper cover it skips the log2 unit and the
// second divider pass. Its work is the 16-step square root, the three-digit
// reciprocal divider (used once or twice) and the log2 unit (normalisation plus
// 16 squaring steps, for depth and step length), and any wait for a result pop.
// Depends on cire_pkg, cire_front, cire_fifo and cire_back.
module canopy_interception_and_rain_energy (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [23:0] i_precip_depth,
    input  logic [1:0]  i_active_layers,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] o_throughfall_depth,
    output logic [31:0] o_kinetic_energy,
    output logic [23:0] o_storage_upper_now,
    output logic [23:0] o_storage_lower_now
);
    import cire_pkg::*;

    t_cfg  r_cfg;
    t_job  fr_job;
    t_job  q_job;
    logic  fr_push;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    logic  fr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{cap_u: '0, cap_l: '0, frac_u: '0, frac_l: '0,
                       hgt_u: '0, hgt_l: '0, under: 1'b0, dt: DT_RESET};
        end else if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                REG_CAP_U:  r_cfg.cap_u  <= i_cfg_data;
                REG_CAP_L:  r_cfg.cap_l  <= i_cfg_data;
                REG_FRAC_U: r_cfg.frac_u <= i_cfg_data[15:0];
                REG_FRAC_L: r_cfg.frac_l <= i_cfg_data[15:0];
                REG_HGT_U:  r_cfg.hgt_u  <= i_cfg_data[15:0];
                REG_HGT_L:  r_cfg.hgt_l  <= i_cfg_data[15:0];
                REG_UNDER:  r_cfg.under  <= i_cfg_data[0];
                REG_DT:     r_cfg.dt     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    cire_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_push          (push),
        .i_precip_depth  (i_precip_depth),
        .i_active_layers (i_active_layers),
        .o_busy          (fr_busy),
        .i_q_full        (q_full),
        .o_job_push      (fr_push),
        .o_job           (fr_job)
    );

    cire_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    cire_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_q_empty           (q_empty),
        .i_job               (q_job),
        .o_q_pop             (q_pop),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_throughfall_depth (o_throughfall_depth),
        .o_kinetic_energy    (o_kinetic_energy),
        .o_storage_upper_now (o_storage_upper_now),
        .o_storage_lower_now (o_storage_lower_now)
    );

    assign full = fr_busy;

endmodule

FILE: sim/canopy_interception_and_rain_energy_test.sv
// self-checking testbench for the canopy interception and rain energy block
// predicts throughfall, layer storage and kinetic energy per transaction
// depends on cire_pkg and canopy_interception_and_rain_energy
`timescale 1ns / 1ps

module canopy_interception_and_rain_energy_test;
    import cire_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 400;

    typedef struct {
        logic [23:0] depth;
        logic [1:0]  layers;
    } t_rain_step;

    typedef struct {
        logic [23:0] throughfall;
        logic [31:0] energy;
        logic [23:0] store_u;
        logic [23:0] store_l;
    } t_canopy_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr = 1'b0;
    logic [2:0]  i_cfg_idx = REG_CAP_U;
    logic [23:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [23:0] i_precip_depth = '0;
    logic [1:0]  i_active_layers = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [23:0] o_throughfall_depth;
    logic [31:0] o_kinetic_energy;
    logic [23:0] o_storage_upper_now;
    logic [23:0] o_storage_lower_now;

    canopy_interception_and_rain_energy dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the configuration and the layer stores
    logic [23:0] cap_sh [LAYERS];
    logic [15:0] frac_sh [LAYERS];
    logic [15:0] hgt_sh [LAYERS];
    logic        under_sh;
    logic [16:0] dt_sh;
    logic [23:0] store_sh [LAYERS];

    t_rain_step  rain_pending [$];
    t_canopy_out canopy_expected [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          recv_hold = 0;
    bit          gaps_on = 1'b1;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_excess = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_q16(longint unsigned x);
        int unsigned n;
        longint unsigned y;
        longint res;
        n = 0;
        while (n < 31 && (x >> (n + 1)) != 0) n++;
        y = x << (31 - n);
        res = longint'(n) * 65536;
        for (int i = 15; i >= 0; i--) begin
            y = (y * y) >> 31;
            if (y >= (64'd1 << 32)) begin
                res += longint'(1) << i;
                y = y >> 1;
            end
        end
        return res;
    endfunction

    function automatic longint unsigned drip_energy(longint unsigned depth, logic [15:0] h);
        longint unsigned s, t;
        s = int_sqrt(longint'(h) << 16);
        t = 1580 * s;
        if (t <= 2404352) return 0;
        return depth * (t - 2404352) / 1600000;
    endfunction

    function automatic longint unsigned splash_energy(longint unsigned p0, longint unsigned f,
                                                      longint unsigned dt);
        longint d16;
        if (p0 == 0 || f >= 32768) return 0;
        d16 = ((longint'(166507) * (log2_q16(p0) - log2_q16(dt))) >>> 16) - 1072824;
        if (d16 <= 0) return 0;
        return p0 * longint'(d16) * (32768 - f) / 64'd8388608000;
    endfunction

    function automatic t_canopy_out intercept_rain(t_rain_step s);
        t_canopy_out o;
        longint p, pf, avail, take;
        longint unsigned ke, f, dt;
        int nact;
        p = s.depth;
        nact = (s.layers > LAYERS) ? LAYERS : s.layers;
        for (int i = 0; i < nact; i++) begin
            f = (frac_sh[i] > 32768) ? 32768 : frac_sh[i];
            pf = (p * longint'(f)) / 32768;
            avail = longint'(cap_sh[i]) - longint'(store_sh[i]);
            take = (avail > pf) ? pf : avail;
            p -= take;
            store_sh[i] = 24'(longint'(store_sh[i]) + take);
        end
        if (under_sh) begin
            ke = (hgt_sh[1] >= 36) ? drip_energy(p, hgt_sh[1]) : 0;
        end else begin
            dt = (dt_sh == 0) ? 1 : dt_sh;
            f = (frac_sh[0] > 32768) ? 32768 : frac_sh[0];
            ke = splash_energy(s.depth, f, dt) + drip_energy(p, hgt_sh[0]);
        end
        o.throughfall = (p > 24'hFFFFFF) ? 24'hFFFFFF : 24'(p);
        o.energy = (ke > 32'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(ke);
        o.store_u = store_sh[0];
        o.store_l = store_sh[1];
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles++;
        if (push && !full) begin
            canopy_expected.push_back(intercept_rain(rain_pending.pop_front()));
            n_sent++;
            send_gap = pick_gap();
        end else if (send_gap > 0) begin
            send_gap--;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && rain_pending.size() > 0 && send_gap == 0) begin
            push <= 1'b1;
            i_precip_depth <= rain_pending[0].depth;
            i_active_layers <= rain_pending[0].layers;
        end else begin
            push <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_canopy_out e;
        if (pop && !empty) begin
            if (canopy_expected.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end else begin
                e = canopy_expected.pop_front();
                n_checked++;
                if (o_throughfall_depth !== e.throughfall) begin
                    $error("throughfall_depth expected %0d got %0d", e.throughfall,
                           o_throughfall_depth);
                    mismatches++;
                end
                if (o_kinetic_energy !== e.energy) begin
                    $error("kinetic_energy expected %0d got %0d", e.energy, o_kinetic_energy);
                    mismatches++;
                end
                if (o_storage_upper_now !== e.store_u) begin
                    $error("storage_upper_now expected %0d got %0d", e.store_u,
                           o_storage_upper_now);
                    mismatches++;
                end
                if (o_storage_lower_now !== e.store_l) begin
                    $error("storage_lower_now expected %0d got %0d", e.store_l,
                           o_storage_lower_now);
                    mismatches++;
                end
            end
            recv_gap = pick_gap();
        end else if (recv_gap > 0) begin
            recv_gap--;
        end
    end

    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold--;
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n && recv_gap == 0;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_wr <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_CAP_U:  cap_sh[0] = val;
            REG_CAP_L:  cap_sh[1] = val;
            REG_FRAC_U: frac_sh[0] = val[15:0];
            REG_FRAC_L: frac_sh[1] = val[15:0];
            REG_HGT_U:  hgt_sh[0] = val[15:0];
            REG_HGT_L:  hgt_sh[1] = val[15:0];
            REG_UNDER:  under_sh = val[0];
            REG_DT:     dt_sh = val[16:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr <= 1'b0;
    endtask

    task automatic set_canopy(logic [23:0] cu, logic [23:0] cl, logic [15:0] fu,
                              logic [15:0] fl, logic [15:0] hu, logic [15:0] hl,
                              logic un, logic [16:0] dt);
        write_reg(REG_CAP_U, cu);
        write_reg(REG_CAP_L, cl);
        write_reg(REG_FRAC_U, 24'(fu));
        write_reg(REG_FRAC_L, 24'(fl));
        write_reg(REG_HGT_U, 24'(hu));
        write_reg(REG_HGT_L, 24'(hl));
        write_reg(REG_UNDER, 24'(un));
        write_reg(REG_DT, 24'(dt));
    endtask

    task automatic queue_rain(logic [23:0] d, logic [1:0] n);
        t_rain_step s;
        s.depth = d;
        s.layers = n;
        rain_pending.push_back(s);
    endtask

    task automatic drain();
        while (rain_pending.size() > 0 || canopy_expected.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_depth();
        case ($urandom_range(0, 4))
            0: return 24'($urandom_range(0, 2000));
            1: return 24'($urandom_range(0, 200000));
            2: return 24'($urandom);
            3: return 24'hFFFFFF - 24'($urandom_range(0, 15));
            default: return 24'($urandom) >> $urandom_range(0, 23);
        endcase
    endfunction

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return FULL_COVER;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [23:0] rand_cap();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 3000));
            1: return 24'($urandom_range(0, 300000));
            2: return 24'($urandom);
            default: return 24'hFFFFFF;
        endcase
    endfunction

    function automatic logic [15:0] rand_height();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(30, 40));
            1: return 16'($urandom_range(0, 8000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_dt();
        case ($urandom_range(0, 4))
            0: return 17'd0;
            1: return 17'd1;
            2: return 17'd86400;
            3: return 17'($urandom);
            default: return 17'($urandom_range(1, 7200));
        endcase
    endfunction

    initial begin
        for (int i = 0; i < LAYERS; i++) begin
            cap_sh[i] = '0;
            frac_sh[i] = '0;
            hgt_sh[i] = '0;
            store_sh[i] = '0;
        end
        under_sh = 1'b0;
        dt_sh = DT_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration, nothing intercepted
        queue_rain(24'd0, 2'd0);
        queue_rain(24'hFFFFFF, 2'd2);
        queue_rain(24'd1, 2'd3);
        drain();

        // extremes: full capacity, cover above full, tallest canopy, shortest step
        set_canopy(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, FULL_COVER, 16'hFFFF, 16'hFFFF, 1'b0, 17'd1);
        queue_rain(24'hFFFFFF, 2'd1);
        queue_rain(24'hFFFFFF, 2'd2);
        queue_rain(24'd0, 2'd2);
        queue_rain(24'd1, 2'd3);
        drain();
        set_canopy(24'd5000, 24'd100, 16'd16384, 16'd8192, 16'd1000, 16'd36, 1'b1, 17'd0);
        queue_rain(24'd40000, 2'd2);
        queue_rain(24'hFFFFFF, 2'd3);
        queue_rain(24'd12345, 2'd1);
        drain();
        // storage above capacity releases its excess, understory just too short
        set_canopy(24'd10, 24'd0, 16'd0, 16'd0, 16'd500, 16'd35, 1'b1, 17'd86400);
        queue_rain(24'd0, 2'd2);
        queue_rain(24'd500, 2'd2);
        drain();
        set_canopy(24'd2000, 24'd2000, 16'd30000, 16'd20000, 16'd0, 16'd0, 1'b0, 17'h1FFFF);
        queue_rain(24'd1, 2'd2);
        queue_rain(24'd999999, 2'd2);
        queue_rain(24'hFFFFFF, 2'd0);
        drain();

        // random phases, one with a long receiver hold-off and one without gaps
        for (int ph = 0; ph < 12; ph++) begin
            set_canopy(rand_cap(), rand_cap(), rand_frac(), rand_frac(), rand_height(),
                       rand_height(), 1'($urandom_range(0, 1)), rand_dt());
            gaps_on = (ph != 3);
            if (ph == 5) recv_hold = 300;
            for (int k = 0; k < 52; k++)
                queue_rain(rand_depth(), 2'($urandom_range(0, 3)));
            drain();
        end

        $display("sent %0d rain transactions over 17 canopy settings, checked %0d results",
                 n_sent, n_checked);
        $display("covered overflow release, cover clamp, both energy paths and stalls");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
